FILE: src/assert_macros.svh
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: src/asr_pkg.sv
`default_nettype none
package asr_pkg;

  localparam int unsigned W = 31;
  localparam logic [W-1:0] ENV_MAX   = 31'h7fffffff;
  localparam logic [W-1:0] ENV_FLOOR = 31'h00000800;

  // stage codes
  localparam logic [1:0] STG_OFF     = 2'd0;
  localparam logic [1:0] STG_ATTACK  = 2'd1;
  localparam logic [1:0] STG_SUSTAIN = 2'd2;
  localparam logic [1:0] STG_RELEASE = 2'd3;

  // input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GATE = 1'b1;

  // register indexes
  localparam logic [2:0] REG_ATK_COEF  = 3'd0;
  localparam logic [2:0] REG_ATK_STEP  = 3'd1;
  localparam logic [2:0] REG_REL_COEF  = 3'd2;
  localparam logic [2:0] REG_REL_STEP  = 3'd3;
  localparam logic [2:0] REG_ATK_SHAPE = 3'd4;
  localparam logic [2:0] REG_REL_SHAPE = 3'd5;

  // multiplier operand A
  localparam logic [1:0] MA_CURVE     = 2'd0;
  localparam logic [1:0] MA_INV_CURVE = 2'd1;
  localparam logic [1:0] MA_RAMP      = 2'd2;
  // multiplier operand B
  localparam logic [1:0] MB_COEF      = 2'd0;
  localparam logic [1:0] MB_SHAPE     = 2'd1;
  localparam logic [1:0] MB_INV_SHAPE = 2'd2;
  // product destination
  localparam logic [1:0] MD_NONE  = 2'd0;
  localparam logic [1:0] MD_CURVE = 2'd1;
  localparam logic [1:0] MD_TERM  = 2'd2;
  localparam logic [1:0] MD_PROD  = 2'd3;
  // curve load
  localparam logic [1:0] CS_NONE  = 2'd0;
  localparam logic [1:0] CS_MAX   = 2'd1;
  localparam logic [1:0] CS_FLOOR = 2'd2;
  // ramp update
  localparam logic [2:0] RO_HOLD = 3'd0;
  localparam logic [2:0] RO_INC  = 3'd1;
  localparam logic [2:0] RO_DEC  = 3'd2;
  localparam logic [2:0] RO_ZERO = 3'd3;
  localparam logic [2:0] RO_MAX  = 3'd4;
  // result emit
  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_SUM  = 2'd1;
  localparam logic [1:0] EM_ZERO = 2'd2;
  localparam logic [1:0] EM_MAX  = 2'd3;
  // jump condition; a taken conditional jump cancels the step's actions
  localparam logic [1:0] JMP_NONE      = 2'd0;
  localparam logic [1:0] JMP_ALWAYS    = 2'd1;
  localparam logic [1:0] JMP_RAMP_MAX  = 2'd2;
  localparam logic [1:0] JMP_RAMP_ZERO = 2'd3;

  // program addresses
  localparam logic [3:0] PC_GATE_ON  = 4'd0;
  localparam logic [3:0] PC_GATE_OFF = 4'd1;
  localparam logic [3:0] PC_NOP      = 4'd2;
  localparam logic [3:0] PC_TICK_OFF = 4'd3;
  localparam logic [3:0] PC_TICK_SUS = 4'd4;
  localparam logic [3:0] PC_ATK_A    = 4'd5;
  localparam logic [3:0] PC_ATK_B    = 4'd6;
  localparam logic [3:0] PC_ATK_C    = 4'd7;
  localparam logic [3:0] PC_ATK_D    = 4'd8;
  localparam logic [3:0] PC_ATK_SAT  = 4'd9;
  localparam logic [3:0] PC_REL_A    = 4'd10;
  localparam logic [3:0] PC_REL_B    = 4'd11;
  localparam logic [3:0] PC_REL_C    = 4'd12;
  localparam logic [3:0] PC_REL_D    = 4'd13;
  localparam logic [3:0] PC_REL_END  = 4'd14;
  localparam logic [3:0] PC_UNUSED   = 4'd15;

  typedef struct packed {
    logic [1:0] mul_a;
    logic [1:0] mul_b;
    logic       rel;
    logic [1:0] mul_dst;
    logic [1:0] curve_set;
    logic [2:0] ramp_op;
    logic       stage_we;
    logic [1:0] stage_val;
    logic [1:0] emit;
    logic [1:0] jmp;
    logic [3:0] target;
    logic       last;
  } ctl_t;

  typedef struct packed {
    logic en;
    ctl_t w;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] stage;
    logic       ramp_max;
    logic       ramp_zero;
    logic       out_valid;
  } stat_t;

  typedef struct packed {
    logic [W-1:0] atk_coef;
    logic [W-1:0] atk_step;
    logic [W-1:0] rel_coef;
    logic [W-1:0] rel_step;
    logic [W-1:0] atk_shape;
    logic [W-1:0] rel_shape;
  } cfg_t;

  function automatic ctl_t ucode(input logic [3:0] pc);
    ctl_t w;
    w = '0;
    case (pc)
      PC_GATE_ON: begin
        w.stage_we = 1'b1; w.stage_val = STG_ATTACK;
        w.curve_set = CS_MAX; w.ramp_op = RO_ZERO; w.last = 1'b1;
      end
      PC_GATE_OFF: begin
        w.stage_we = 1'b1; w.stage_val = STG_RELEASE;
        w.curve_set = CS_MAX; w.ramp_op = RO_MAX; w.last = 1'b1;
      end
      PC_TICK_OFF: begin
        w.emit = EM_ZERO; w.last = 1'b1;
      end
      PC_TICK_SUS: begin
        w.emit = EM_MAX; w.last = 1'b1;
      end
      PC_ATK_A: begin
        w.jmp = JMP_RAMP_MAX; w.target = PC_ATK_SAT;
        w.mul_a = MA_CURVE; w.mul_b = MB_COEF; w.mul_dst = MD_CURVE;
        w.ramp_op = RO_INC;
      end
      PC_ATK_B: begin
        w.mul_a = MA_INV_CURVE; w.mul_b = MB_SHAPE; w.mul_dst = MD_TERM;
      end
      PC_ATK_C: begin
        w.mul_a = MA_RAMP; w.mul_b = MB_INV_SHAPE; w.mul_dst = MD_PROD;
      end
      PC_ATK_D: begin
        w.emit = EM_SUM; w.last = 1'b1;
      end
      PC_ATK_SAT: begin
        w.stage_we = 1'b1; w.stage_val = STG_SUSTAIN;
        w.jmp = JMP_ALWAYS; w.target = PC_ATK_B;
      end
      PC_REL_A: begin
        w.jmp = JMP_RAMP_ZERO; w.target = PC_REL_END; w.rel = 1'b1;
        w.mul_a = MA_CURVE; w.mul_b = MB_COEF; w.mul_dst = MD_CURVE;
        w.ramp_op = RO_DEC;
      end
      PC_REL_B: begin
        w.rel = 1'b1;
        w.mul_a = MA_CURVE; w.mul_b = MB_SHAPE; w.mul_dst = MD_TERM;
      end
      PC_REL_C: begin
        w.rel = 1'b1;
        w.mul_a = MA_RAMP; w.mul_b = MB_INV_SHAPE; w.mul_dst = MD_PROD;
      end
      PC_REL_D: begin
        w.emit = EM_SUM; w.last = 1'b1;
      end
      PC_REL_END: begin
        w.stage_we = 1'b1; w.stage_val = STG_OFF;
        w.curve_set = CS_FLOOR; w.emit = EM_ZERO; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // dispatch: program entry for an accepted item
  function automatic logic [3:0] entry_pc(input logic op, input logic gate,
                                          input logic [1:0] stage);
    logic [3:0] pc;
    pc = PC_NOP;
    if (op == OP_GATE) begin
      if (gate) begin
        pc = PC_GATE_ON;
      end else if (stage == STG_ATTACK || stage == STG_SUSTAIN) begin
        pc = PC_GATE_OFF;
      end
    end else begin
      case (stage)
        STG_OFF:     pc = PC_TICK_OFF;
        STG_ATTACK:  pc = PC_ATK_A;
        STG_SUSTAIN: pc = PC_TICK_SUS;
        STG_RELEASE: pc = PC_REL_A;
        default:     pc = PC_NOP;
      endcase
    end
    return pc;
  endfunction

endpackage
`default_nettype wire

FILE: src/asr_dp.sv
`default_nettype none
module asr_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire asr_pkg::dp_ctl_t    ctl,
  input  wire asr_pkg::cfg_t       cfg,
  input  wire logic                out_ready,
  output asr_pkg::stat_t           stat,
  output logic                     out_valid,
  output logic [asr_pkg::W-1:0]    sample,
  output logic [1:0]               stage
);

  logic [1:0]            stage_reg;
  logic [1:0]            stage_next;
  logic [asr_pkg::W-1:0] curve;
  logic [asr_pkg::W-1:0] ramp;
  logic [asr_pkg::W-1:0] term;
  logic [asr_pkg::W-1:0] prod;
  logic [asr_pkg::W-1:0] coef, shape, step;
  logic [asr_pkg::W-1:0] op_a, op_b;
  logic [2*asr_pkg::W-1:0] mul_full;
  logic [asr_pkg::W-1:0] qprod;
  logic [asr_pkg::W:0]   ramp_sum;
  logic [asr_pkg::W-1:0] ramp_inc, ramp_dec;
  logic [asr_pkg::W:0]   blend_sum;
  logic [asr_pkg::W-1:0] blend_sat;

  assign coef  = ctl.w.rel ? cfg.rel_coef  : cfg.atk_coef;
  assign shape = ctl.w.rel ? cfg.rel_shape : cfg.atk_shape;
  assign step  = ctl.w.rel ? cfg.rel_step  : cfg.atk_step;

  always_comb begin
    case (ctl.w.mul_a)
      asr_pkg::MA_INV_CURVE: op_a = asr_pkg::ENV_MAX - curve;
      asr_pkg::MA_RAMP:      op_a = ramp;
      default:               op_a = curve;
    endcase
    case (ctl.w.mul_b)
      asr_pkg::MB_SHAPE:     op_b = shape;
      asr_pkg::MB_INV_SHAPE: op_b = asr_pkg::ENV_MAX - shape;
      default:               op_b = coef;
    endcase
  end

  // Q31 product, truncating
  assign mul_full = (2*asr_pkg::W)'(op_a) * (2*asr_pkg::W)'(op_b);
  assign qprod    = mul_full[2*asr_pkg::W-1:asr_pkg::W];

  assign ramp_sum = {1'b0, ramp} + {1'b0, step};
  assign ramp_inc = ramp_sum[asr_pkg::W] ? asr_pkg::ENV_MAX : ramp_sum[asr_pkg::W-1:0];
  assign ramp_dec = (ramp > step) ? (ramp - step) : '0;

  assign blend_sum = {1'b0, term} + {1'b0, prod};
  assign blend_sat = blend_sum[asr_pkg::W] ? asr_pkg::ENV_MAX : blend_sum[asr_pkg::W-1:0];

  assign stage_next = (ctl.en && ctl.w.stage_we) ? ctl.w.stage_val : stage_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg <= asr_pkg::STG_OFF;
      curve     <= asr_pkg::ENV_FLOOR;
      ramp      <= '0;
    end else if (ctl.en) begin
      stage_reg <= stage_next;
      if (ctl.w.mul_dst == asr_pkg::MD_CURVE) begin
        curve <= qprod;
      end else if (ctl.w.curve_set == asr_pkg::CS_MAX) begin
        curve <= asr_pkg::ENV_MAX;
      end else if (ctl.w.curve_set == asr_pkg::CS_FLOOR) begin
        curve <= asr_pkg::ENV_FLOOR;
      end
      case (ctl.w.ramp_op)
        asr_pkg::RO_INC:  ramp <= ramp_inc;
        asr_pkg::RO_DEC:  ramp <= ramp_dec;
        asr_pkg::RO_ZERO: ramp <= '0;
        asr_pkg::RO_MAX:  ramp <= asr_pkg::ENV_MAX;
        default:          ramp <= ramp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.w.mul_dst == asr_pkg::MD_TERM) begin
      term <= qprod;
    end
    if (ctl.en && ctl.w.mul_dst == asr_pkg::MD_PROD) begin
      prod <= qprod;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en && ctl.w.emit != asr_pkg::EM_NONE) begin
      out_valid <= 1'b1;
      stage     <= stage_next;
      case (ctl.w.emit)
        asr_pkg::EM_SUM: sample <= blend_sat;
        asr_pkg::EM_MAX: sample <= asr_pkg::ENV_MAX;
        default:         sample <= '0;
      endcase
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.stage     = stage_reg;
  assign stat.ramp_max  = (ramp == asr_pkg::ENV_MAX);
  assign stat.ramp_zero = (ramp == '0);
  assign stat.out_valid = out_valid;

endmodule
`default_nettype wire

FILE: src/asr_seq.sv
`default_nettype none
`include "assert_macros.svh"
module asr_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             operation,
  input  wire logic             gate_level,
  input  wire logic             out_ready,
  input  wire asr_pkg::stat_t   stat,
  output logic                  in_ready,
  output asr_pkg::dp_ctl_t      ctl
);

  logic           busy;
  logic [3:0]     pc;
  asr_pkg::ctl_t  w;
  logic           cond_hit;
  logic           skip;
  logic           stall;
  logic           done;
  logic [1:0]     stage_after;
  logic [3:0]     entry;

  assign w = asr_pkg::ucode(pc);

  always_comb begin
    case (w.jmp)
      asr_pkg::JMP_ALWAYS:    cond_hit = 1'b1;
      asr_pkg::JMP_RAMP_MAX:  cond_hit = stat.ramp_max;
      asr_pkg::JMP_RAMP_ZERO: cond_hit = stat.ramp_zero;
      default:                cond_hit = 1'b0;
    endcase
  end

  assign skip  = cond_hit && (w.jmp != asr_pkg::JMP_ALWAYS);
  assign stall = (w.emit != asr_pkg::EM_NONE) && stat.out_valid && !out_ready;
  assign done  = busy && !stall && w.last;

  assign ctl.en = busy && !stall && !skip;
  assign ctl.w  = w;

  assign in_ready = !busy || done;

  // stage as it stands after this cycle's step, for dispatch of the next item
  assign stage_after = (ctl.en && w.stage_we) ? w.stage_val : stat.stage;
  assign entry       = asr_pkg::entry_pc(operation, gate_level, stage_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= asr_pkg::PC_NOP;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      pc   <= entry;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && !stall) begin
      pc <= cond_hit ? w.target : pc + 4'd1;
    end
  end

  `ASSERT_CLK(a_stall_holds, clk, rst, (busy && stall) |=> (busy && $stable(pc)), "step advanced while output held")
  `ASSERT_CLK(a_accept_busy, clk, rst, (in_valid && in_ready) |=> busy, "accepted item not started")
  `ASSERT_NEVER(a_no_unused, clk, rst, busy && pc == asr_pkg::PC_UNUSED, "program ran off its end")
  `ASSERT_CLK(a_done_idle, clk, rst, (done && !in_valid) |=> !busy, "sequencer did not retire")

endmodule
`default_nettype wire

FILE: src/asr_envelope_generator_top.sv
`default_nettype none
// ASR envelope generator, Q31.
// Input channel (in_valid/in_ready): operation 0 = sample tick, 1 = gate change;
// gate_level picks gate on (1) or off (0). A gate change gives no result; a tick
// gives exactly one transfer on the output channel (out_valid/out_ready) with
// the envelope sample and the stage after the tick.
// Config: cfg_we/cfg_index/cfg_data write one of six 31-bit registers per cycle;
// idx > 5 dropped; user must write only while the block is idle (not enforced).
// Timing: a microcoded sequencer steps one control word per cycle (held while a
// result waits on a stalled receiver) through a shared 31x31 multiplier. Attack
// and release ticks take 4 steps (3 multiplies plus the blend/saturate step), 5
// when attack hits full scale; sustain, off and gate changes take 1 step, a
// release tick that finds the ramp at zero 2. The last step writes the result
// into the output register. The next item is taken in the last step's cycle, so
// items follow one another with no idle step between them.
// Reset: stage off, curve 0x800, ramp 0, registers at their defaults, no result
// pending. When the receiver stalls, the result waits in the output register;
// the sequencer holds at its next emitting step and stops taking input there.
module asr_envelope_generator_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // item channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     operation,
  input  wire logic                     gate_level,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [asr_pkg::W-1:0]         sample,
  output logic [1:0]                    stage,
  // register write port
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [asr_pkg::W-1:0]    cfg_data
);

  asr_pkg::cfg_t    cfg;
  asr_pkg::dp_ctl_t ctl;
  asr_pkg::stat_t   stat;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.atk_coef  <= 31'd2146863454;
      cfg.atk_step  <= 31'd44739;
      cfg.rel_coef  <= 31'd2146863454;
      cfg.rel_step  <= 31'd44739;
      cfg.atk_shape <= '0;
      cfg.rel_shape <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        asr_pkg::REG_ATK_COEF:  cfg.atk_coef  <= cfg_data;
        asr_pkg::REG_ATK_STEP:  cfg.atk_step  <= cfg_data;
        asr_pkg::REG_REL_COEF:  cfg.rel_coef  <= cfg_data;
        asr_pkg::REG_REL_STEP:  cfg.rel_step  <= cfg_data;
        asr_pkg::REG_ATK_SHAPE: cfg.atk_shape <= cfg_data;
        asr_pkg::REG_REL_SHAPE: cfg.rel_shape <= cfg_data;
        default: ;
      endcase
    end
  end

  // control: step counter, program ROM, dispatch
  asr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .operation  (operation),
    .gate_level (gate_level),
    .out_ready  (out_ready),
    .stat       (stat),
    .in_ready   (in_ready),
    .ctl        (ctl)
  );

  // datapath: envelope state, shared multiplier, output register
  asr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .sample    (sample),
    .stage     (stage)
  );

endmodule
`default_nettype wire
